// File: design/rc4_pkg.sv
// ----------------------------------------------------------------------------
// RC4 stream cipher package
// Shared constants, register indexes and the sequencer program.
// ----------------------------------------------------------------------------
package rc4_pkg;

  localparam int BYTE_W     = 8;
  localparam int BOX_DEPTH  = 256;
  localparam int KEY_WORDS  = 4;
  localparam int KEY_LEN_W  = 6;
  localparam int KIDX_W     = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int PC_W       = 4;

  // Largest usable key length, bounded by the bytes the key registers hold.
  localparam logic [KEY_LEN_W-1:0] KEY_LEN_MAX   = 6'd32;
  localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 6'd16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_3 = 3'd4;

  // Request action codes.
  localparam logic ACT_RESTART = 1'b0;
  localparam logic ACT_DATA    = 1'b1;

  // Program addresses.
  localparam logic [PC_W-1:0] PC_IDLE = 4'd0;
  localparam logic [PC_W-1:0] PC_G0   = 4'd1;
  localparam logic [PC_W-1:0] PC_G1   = 4'd2;
  localparam logic [PC_W-1:0] PC_G2   = 4'd3;
  localparam logic [PC_W-1:0] PC_G3   = 4'd4;
  localparam logic [PC_W-1:0] PC_R0   = 4'd5;
  localparam logic [PC_W-1:0] PC_K0   = 4'd6;
  localparam logic [PC_W-1:0] PC_K1   = 4'd7;
  localparam logic [PC_W-1:0] PC_K2   = 4'd8;
  localparam logic [PC_W-1:0] PC_K3   = 4'd9;
  localparam logic [PC_W-1:0] PC_R1   = 4'd10;

  typedef enum logic [1:0] {I_HOLD, I_INC, I_CLR} i_op_t;
  typedef enum logic [1:0] {J_HOLD, J_ADD, J_CLR} j_op_t;
  typedef enum logic [2:0] {A_I, A_I_NEXT, A_J_NEXT, A_T, A_HOLD} addr_sel_t;
  typedef enum logic [1:0] {W_NONE, W_I_RD, W_J_SI} wr_sel_t;
  typedef enum logic [1:0] {C_NEXT, C_DISPATCH, C_OUT_FREE, C_LOOP} cond_t;

  typedef struct packed {
    i_op_t           i_op;
    j_op_t           j_op;
    addr_sel_t       addr;
    wr_sel_t         wr;
    logic            si_ld;
    logic            sj_ld;
    logic            key_use;
    logic            kidx_step;
    logic            init;
    logic            out_ld;
    cond_t           cond;
    logic [PC_W-1:0] nxt;
    logic [PC_W-1:0] alt;
  } uc_t;

  // Control store. The dispatch step takes alt on a restart request, and the
  // loop step takes alt while more schedule steps remain.
  function automatic uc_t uc_rom(input logic [PC_W-1:0] pc);
    uc_t w;
    w = '{i_op: I_HOLD, j_op: J_HOLD, addr: A_I, wr: W_NONE, si_ld: 1'b0,
          sj_ld: 1'b0, key_use: 1'b0, kidx_step: 1'b0, init: 1'b0,
          out_ld: 1'b0, cond: C_NEXT, nxt: PC_IDLE, alt: PC_IDLE};
    case (pc)
      PC_IDLE: begin
        w.cond = C_DISPATCH;
        w.nxt  = PC_G0;
        w.alt  = PC_R0;
      end
      PC_G0: begin
        w.i_op = I_INC;
        w.addr = A_I_NEXT;
        w.nxt  = PC_G1;
      end
      PC_G1: begin
        w.si_ld = 1'b1;
        w.j_op  = J_ADD;
        w.addr  = A_J_NEXT;
        w.nxt   = PC_G2;
      end
      PC_G2: begin
        w.wr    = W_I_RD;
        w.sj_ld = 1'b1;
        w.addr  = A_T;
        w.nxt   = PC_G3;
      end
      PC_G3: begin
        w.wr     = W_J_SI;
        w.addr   = A_HOLD;
        w.out_ld = 1'b1;
        w.cond   = C_OUT_FREE;
        w.nxt    = PC_IDLE;
      end
      PC_R0: begin
        w.init = 1'b1;
        w.i_op = I_CLR;
        w.j_op = J_CLR;
        w.nxt  = PC_K0;
      end
      PC_K0: begin
        w.addr = A_I;
        w.nxt  = PC_K1;
      end
      PC_K1: begin
        w.si_ld   = 1'b1;
        w.j_op    = J_ADD;
        w.key_use = 1'b1;
        w.addr    = A_J_NEXT;
        w.nxt     = PC_K2;
      end
      PC_K2: begin
        w.wr  = W_I_RD;
        w.nxt = PC_K3;
      end
      PC_K3: begin
        w.wr        = W_J_SI;
        w.i_op      = I_INC;
        w.kidx_step = 1'b1;
        w.cond      = C_LOOP;
        w.nxt       = PC_R1;
        w.alt       = PC_K0;
      end
      PC_R1: begin
        w.j_op = J_CLR;
        w.nxt  = PC_IDLE;
      end
      default: begin
        w.nxt = PC_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// File: design/rc4_in_if.sv
// ----------------------------------------------------------------------------
// RC4 input channel
// Valid/ready channel carrying one restart or data request.
// ----------------------------------------------------------------------------
interface rc4_in_if;
  logic                       valid;
  logic                       ready;
  logic                       action;
  logic [rc4_pkg::BYTE_W-1:0] data_in;
  logic                       end_of_message;

  modport source (output valid, action, data_in, end_of_message, input ready);
  modport sink   (input valid, action, data_in, end_of_message, output ready);
endinterface

// File: design/rc4_out_if.sv
// ----------------------------------------------------------------------------
// RC4 result channel
// Valid/ready channel carrying one processed byte and its keystream byte.
// ----------------------------------------------------------------------------
interface rc4_out_if;
  logic                       valid;
  logic                       ready;
  logic [rc4_pkg::BYTE_W-1:0] data_out;
  logic [rc4_pkg::BYTE_W-1:0] keystream;
  logic                       last;

  modport source (output valid, data_out, keystream, last, input ready);
  modport sink   (input valid, data_out, keystream, last, output ready);
endinterface

// File: design/rc4_cfg_if.sv
// ----------------------------------------------------------------------------
// RC4 configuration channel
// Valid/ready register write channel with register index and write data.
// ----------------------------------------------------------------------------
interface rc4_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [rc4_pkg::CFG_IDX_W-1:0]  index;
  logic [rc4_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: design/rc4_stream_cipher_unit.sv
// ----------------------------------------------------------------------------
// RC4 stream cipher unit
// Microcoded sequencer over one 256 x 8 permutation memory: key schedule on
// a restart request, one keystream byte per data request.
// ----------------------------------------------------------------------------
//  Channel  Role    Payload                              Handshake
//  in_ch    sink    action, data_in, end_of_message      valid/ready
//  out_ch   source  data_out, keystream, last            valid/ready
//  cfg_ch   sink    index, data (key_length, key words)  valid/ready, always ready
//
//  A data request steps through G0 to G3: the dependent reads of S[i], S[j] and
//  S[t] and the two swap writes share the single permutation memory port pair.
//  A restart request runs R0, then 256 schedule steps through K0 to K3, then R1.
//  On reset the permutation is the identity through per-entry valid bits. A
//  full result register stalls the last step of a data request; a new request
//  is taken while an earlier result waits.
// ----------------------------------------------------------------------------
module rc4_stream_cipher_unit (
  input  logic       clk,
  input  logic       rst_n,
  rc4_in_if.sink     in_ch,
  rc4_out_if.source  out_ch,
  rc4_cfg_if.sink    cfg_ch
);

  localparam int BW = rc4_pkg::BYTE_W;

  // Configuration registers.
  logic [rc4_pkg::KEY_LEN_W-1:0]  key_len_r;
  logic [rc4_pkg::CFG_DATA_W-1:0] key_word_r [rc4_pkg::KEY_WORDS];
  logic [rc4_pkg::CFG_IDX_W-1:0]  cfg_widx;

  // Sequencer and datapath.
  logic [rc4_pkg::PC_W-1:0] pc_r, pc_nxt;
  rc4_pkg::uc_t             uc;
  logic [BW-1:0]            i_r, i_nxt;
  logic [BW-1:0]            j_r, j_nxt;
  logic [rc4_pkg::KIDX_W-1:0] kidx_r;
  logic [BW-1:0]            si_r, sj_r;
  logic                     hit_i_r, hit_j_r;
  logic [BW-1:0]            data_r;
  logic                     eom_r;

  // Permutation memory with valid bits; an entry never written holds its index.
  logic [BW-1:0]            box_mem [rc4_pkg::BOX_DEPTH];
  logic [rc4_pkg::BOX_DEPTH-1:0] vld_r;
  logic [BW-1:0]            rd_addr, rd_addr_r, rd_data_r, rdata;
  logic                     rd_vld_r;
  logic                     wr_en;
  logic [BW-1:0]            wr_addr, wr_data;

  logic [BW-1:0]            kbyte, j_sum, t_addr, ks;
  logic [rc4_pkg::KEY_LEN_W-1:0] eff_len;
  logic                     in_acc, out_free;

  logic                     out_vld_r;
  logic [BW-1:0]            data_out_r, keystream_r;
  logic                     last_r;

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  assign cfg_ch.ready = 1'b1;
  assign cfg_widx     = cfg_ch.index - rc4_pkg::CFG_KEY_WORD_0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_len_r <= rc4_pkg::KEY_LEN_RESET;
      for (int k = 0; k < rc4_pkg::KEY_WORDS; k++) begin
        key_word_r[k] <= '0;
      end
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index == rc4_pkg::CFG_KEY_LENGTH) begin
        key_len_r <= cfg_ch.data[rc4_pkg::KEY_LEN_W-1:0];
      end else if (cfg_ch.index inside
                   {[rc4_pkg::CFG_KEY_WORD_0:rc4_pkg::CFG_KEY_WORD_3]}) begin
        key_word_r[cfg_widx[1:0]] <= cfg_ch.data;
      end
    end
  end

  // Zero length counts as one byte; lengths above the register space saturate.
  always_comb begin
    if (key_len_r == '0) begin
      eff_len = rc4_pkg::KEY_LEN_W'(1);
    end else if (key_len_r > rc4_pkg::KEY_LEN_MAX) begin
      eff_len = rc4_pkg::KEY_LEN_MAX;
    end else begin
      eff_len = key_len_r;
    end
  end

  assign kbyte = key_word_r[kidx_r[4:3]][{kidx_r[2:0], 3'b000} +: BW];

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  assign uc          = rc4_pkg::uc_rom(pc_r);
  assign in_ch.ready = (pc_r == rc4_pkg::PC_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_vld_r || out_ch.ready;

  always_comb begin
    case (uc.cond)
      rc4_pkg::C_NEXT: begin
        pc_nxt = uc.nxt;
      end
      rc4_pkg::C_DISPATCH: begin
        if (!in_acc) begin
          pc_nxt = pc_r;
        end else if (in_ch.action == rc4_pkg::ACT_DATA) begin
          pc_nxt = uc.nxt;
        end else begin
          pc_nxt = uc.alt;
        end
      end
      rc4_pkg::C_OUT_FREE: begin
        pc_nxt = out_free ? uc.nxt : pc_r;
      end
      rc4_pkg::C_LOOP: begin
        pc_nxt = (i_r != '1) ? uc.alt : uc.nxt;
      end
      default: begin
        pc_nxt = rc4_pkg::PC_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Datapath
  // --------------------------------------------------------------------------
  assign rdata  = rd_vld_r ? rd_data_r : rd_addr_r;
  assign j_sum  = j_r + rdata + (uc.key_use ? kbyte : '0);
  assign t_addr = si_r + rdata;

  always_comb begin
    case (uc.i_op)
      rc4_pkg::I_INC: i_nxt = i_r + 1'b1;
      rc4_pkg::I_CLR: i_nxt = '0;
      default:        i_nxt = i_r;
    endcase
    case (uc.j_op)
      rc4_pkg::J_ADD: j_nxt = j_sum;
      rc4_pkg::J_CLR: j_nxt = '0;
      default:        j_nxt = j_r;
    endcase
  end

  always_comb begin
    case (uc.addr)
      rc4_pkg::A_I_NEXT: rd_addr = i_r + 1'b1;
      rc4_pkg::A_J_NEXT: rd_addr = j_sum;
      rc4_pkg::A_T:      rd_addr = t_addr;
      rc4_pkg::A_HOLD:   rd_addr = rd_addr_r;
      default:           rd_addr = i_r;
    endcase
  end

  assign wr_en   = (uc.wr != rc4_pkg::W_NONE);
  assign wr_addr = (uc.wr == rc4_pkg::W_I_RD) ? i_r : j_r;
  assign wr_data = (uc.wr == rc4_pkg::W_I_RD) ? rdata : si_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      box_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= box_mem[rd_addr];
    rd_vld_r  <= vld_r[rd_addr];
    rd_addr_r <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (uc.init) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r   <= rc4_pkg::PC_IDLE;
      i_r    <= '0;
      j_r    <= '0;
      kidx_r <= '0;
    end else begin
      pc_r <= pc_nxt;
      i_r  <= i_nxt;
      j_r  <= j_nxt;
      if (uc.init) begin
        kidx_r <= '0;
      end else if (uc.kidx_step) begin
        if (({1'b0, kidx_r} + 1'b1) >= eff_len) begin
          kidx_r <= '0;
        end else begin
          kidx_r <= kidx_r + 1'b1;
        end
      end
    end
  end

  // The keystream read is issued while the swap is still being written back,
  // so the two swapped entries are forwarded from the registers.
  always_ff @(posedge clk) begin
    if (uc.si_ld) begin
      si_r <= rdata;
    end
    if (uc.sj_ld) begin
      sj_r    <= rdata;
      hit_i_r <= (t_addr == i_r);
      hit_j_r <= (t_addr == j_r);
    end
    if (in_acc) begin
      data_r <= in_ch.data_in;
      eom_r  <= in_ch.end_of_message;
    end
  end

  assign ks = hit_j_r ? si_r : (hit_i_r ? sj_r : rdata);

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (uc.out_ld && out_free) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (uc.out_ld && out_free) begin
      data_out_r  <= data_r ^ ks;
      keystream_r <= ks;
      last_r      <= eom_r;
    end
  end

  assign out_ch.valid     = out_vld_r;
  assign out_ch.data_out  = data_out_r;
  assign out_ch.keystream = keystream_r;
  assign out_ch.last      = last_r;

endmodule

// File: verif/rc4_stream_cipher_unit_test.sv
// ----------------------------------------------------------------------------
// RC4 stream cipher unit testbench
// Sends restart and data requests with random stalls on both channels and
// rewrites the key between phases. Every cipher byte is checked against a
// behavioral model of the key schedule and of the keystream generator, or against fixed values.
// ----------------------------------------------------------------------------
module rc4_stream_cipher_unit_test;
  import rc4_pkg::*;

  localparam int     TARGET_REQUESTS = 650;
  localparam int     CALM_FROM       = 570;
  localparam int     SCHEDULE_WAIT   = 1100;
  localparam int     TAIL_WAIT       = 16;
  localparam longint CYCLE_LIMIT     = 1000000;

  localparam logic [CFG_IDX_W-1:0] CFG_PAST_END = CFG_KEY_WORD_3 + 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_LAST = {CFG_IDX_W{1'b1}};
  localparam logic [CFG_DATA_W-1:0] ALL_ONES    = {CFG_DATA_W{1'b1}};

  typedef enum logic {ROW_REG_WRITE, ROW_REQUEST} row_kind_t;

  typedef struct {
    row_kind_t              kind;
    logic [CFG_IDX_W-1:0]   reg_idx;
    logic [CFG_DATA_W-1:0]  reg_val;
    logic                   act;
    logic [BYTE_W-1:0]      data;
    logic                   eom;
    bit                     known;
    logic [BYTE_W-1:0]      known_ks;
  } directed_row_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_out;
    logic [BYTE_W-1:0] keystream;
    logic              last;
  } cipher_byte_t;

  logic clk = 1'b0;
  logic rst_n;

  rc4_in_if  in_ch ();
  rc4_out_if out_ch ();
  rc4_cfg_if cfg_ch ();

  rc4_stream_cipher_unit DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #1 clk = ~clk;

  // Model of the permutation, the two indices and the key registers.
  logic [BYTE_W-1:0]     sbox [BOX_DEPTH];
  logic [BYTE_W-1:0]     idx_i;
  logic [BYTE_W-1:0]     idx_j;
  logic [KEY_LEN_W-1:0]  key_len_reg;
  logic [CFG_DATA_W-1:0] key_reg [KEY_WORDS];

  cipher_byte_t  expected_bytes [$];
  directed_row_t script [$];

  bit     throttle_in      = 1'b0;
  bit     throttle_out     = 1'b0;
  bit     schedule_pending = 1'b0;
  int     requests_sent    = 0;
  int     restarts_sent    = 0;
  int     reg_writes       = 0;
  int     bytes_checked    = 0;
  int     errors           = 0;
  longint cycles           = 0;

  function automatic void apply_reg_write(input logic [CFG_IDX_W-1:0]  idx,
                                          input logic [CFG_DATA_W-1:0] val);
    if (idx == CFG_KEY_LENGTH) begin
      key_len_reg = val[KEY_LEN_W-1:0];
    end else if (idx >= CFG_KEY_WORD_0 && idx <= CFG_KEY_WORD_3) begin
      key_reg[idx - CFG_KEY_WORD_0] = val;
    end
  endfunction

  function automatic void schedule_key();
    int unsigned       len;
    int unsigned       kn;
    int                n;
    logic [BYTE_W-1:0] acc;
    logic [BYTE_W-1:0] tmp;
    len = key_len_reg;
    if (len == 0) len = 1;
    if (len > KEY_LEN_MAX) len = KEY_LEN_MAX;
    for (n = 0; n < BOX_DEPTH; n++) sbox[n] = BYTE_W'(n);
    acc = '0;
    for (n = 0; n < BOX_DEPTH; n++) begin
      kn      = n % len;
      acc     = acc + sbox[n] + key_reg[kn / 8][8 * (kn % 8) +: 8];
      tmp     = sbox[n];
      sbox[n] = sbox[acc];
      sbox[acc] = tmp;
    end
    idx_i = '0;
    idx_j = '0;
  endfunction

  function automatic logic [BYTE_W-1:0] next_keystream();
    logic [BYTE_W-1:0] tmp;
    logic [BYTE_W-1:0] tsum;
    idx_i = idx_i + 1'b1;
    idx_j = idx_j + sbox[idx_i];
    tmp         = sbox[idx_i];
    sbox[idx_i] = sbox[idx_j];
    sbox[idx_j] = tmp;
    tsum = sbox[idx_i] + sbox[idx_j];
    return sbox[tsum];
  endfunction

  function automatic logic [CFG_DATA_W-1:0] random_word();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return ALL_ONES;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic directed_row_t req_row(input logic act, input logic [BYTE_W-1:0] data,
                                            input logic eom);
    directed_row_t r;
    r = '{kind: ROW_REQUEST, reg_idx: CFG_KEY_LENGTH, reg_val: '0, act: act, data: data,
          eom: eom, known: 1'b0, known_ks: '0};
    return r;
  endfunction

  function automatic directed_row_t known_row(input logic [BYTE_W-1:0] data, input logic eom,
                                              input logic [BYTE_W-1:0] ks);
    directed_row_t r;
    r = req_row(ACT_DATA, data, eom);
    r.known    = 1'b1;
    r.known_ks = ks;
    return r;
  endfunction

  function automatic directed_row_t reg_row(input logic [CFG_IDX_W-1:0]  idx,
                                            input logic [CFG_DATA_W-1:0] val);
    directed_row_t r;
    r = req_row(ACT_DATA, '0, 1'b0);
    r.kind    = ROW_REG_WRITE;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  function automatic void add_row(input directed_row_t r);
    script.insert(script.size(), r);
  endfunction

  task automatic in_release();
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  task automatic send_request(input logic act, input logic [BYTE_W-1:0] data, input logic eom,
                              input bit known, input logic [BYTE_W-1:0] known_ks);
    logic [BYTE_W-1:0] ks;
    if (requests_sent >= CALM_FROM) begin
      throttle_in  = 1'b0;
      throttle_out = 1'b0;
    end
    if (throttle_in && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(0, 15)) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid          <= 1'b1;
    in_ch.action         <= act;
    in_ch.data_in        <= data;
    in_ch.end_of_message <= eom;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    requests_sent++;
    if (act == ACT_RESTART) begin
      schedule_key();
      restarts_sent++;
      schedule_pending = 1'b1;
    end else begin
      // The block took a data request, so any key schedule has finished.
      schedule_pending = 1'b0;
      ks = next_keystream();
      if (known) ks = known_ks;
      expected_bytes.insert(expected_bytes.size(),
                            cipher_byte_t'{data_out: data ^ ks, keystream: ks, last: eom});
    end
  endtask

  // Registers may only change while the block is idle: all results are back
  // and no key schedule can still be running.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    if (in_ch.valid) in_release();
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (schedule_pending ? SCHEDULE_WAIT : 2) @(posedge clk);
    schedule_pending = 1'b0;
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    apply_reg_write(idx, val);
    reg_writes++;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: no progress within the cycle limit", $time);
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    cipher_byte_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected byte: expected none, got data_out=%h keystream=%h last=%b",
                 $time, out_ch.data_out, out_ch.keystream, out_ch.last);
        errors++;
      end else begin
        want = expected_bytes.pop_front();
        bytes_checked++;
        if (out_ch.data_out !== want.data_out) begin
          $display("%0t: data_out expected %h got %h", $time, want.data_out, out_ch.data_out);
          errors++;
        end
        if (out_ch.keystream !== want.keystream) begin
          $display("%0t: keystream expected %h got %h", $time, want.keystream,
                   out_ch.keystream);
          errors++;
        end
        if (out_ch.last !== want.last) begin
          $display("%0t: last expected %b got %b", $time, want.last, out_ch.last);
          errors++;
        end
      end
    end
  end

  // Result side: ready drops in random bursts while throttling is on.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (throttle_out && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(0, 15)) @(negedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    int                    k;
    int                    m;
    int                    b;
    int                    msgs;
    int                    msg_len;
    logic                  eom;
    logic [KEY_LEN_W-1:0]  len;
    logic [CFG_DATA_W-1:0] val;

    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.action         = ACT_DATA;
    in_ch.data_in        = '0;
    in_ch.end_of_message = 1'b0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.index         = CFG_KEY_LENGTH;
    cfg_ch.data          = '0;

    for (k = 0; k < BOX_DEPTH; k++) sbox[k] = BYTE_W'(k);
    idx_i       = '0;
    idx_j       = '0;
    key_len_reg = KEY_LEN_RESET;
    for (k = 0; k < KEY_WORDS; k++) key_reg[k] = '0;

    // Straight after reset the permutation is the identity, which gives the
    // keystream 2, 5, 7 before any restart.
    add_row(known_row(8'h00, 1'b0, 8'h02));
    add_row(known_row(8'hFF, 1'b1, 8'h05));
    add_row(known_row(8'hA5, 1'b0, 8'h07));
    add_row(req_row(ACT_RESTART, 8'hFF, 1'b1));
    add_row(req_row(ACT_DATA, 8'h00, 1'b0));
    add_row(req_row(ACT_DATA, 8'hFF, 1'b1));
    // A zero key length acts as a single key byte.
    add_row(reg_row(CFG_KEY_LENGTH, '0));
    add_row(reg_row(CFG_KEY_WORD_0, ALL_ONES));
    add_row(req_row(ACT_RESTART, 8'h00, 1'b0));
    add_row(req_row(ACT_DATA, 8'h5A, 1'b1));
    // The largest length saturates to the 32 bytes the key words hold.
    add_row(reg_row(CFG_KEY_LENGTH, ALL_ONES));
    add_row(reg_row(CFG_KEY_WORD_0 + 3'd1, 64'h0123_4567_89AB_CDEF));
    add_row(reg_row(CFG_KEY_WORD_0 + 3'd2, 64'hFEDC_BA98_7654_3210));
    add_row(reg_row(CFG_KEY_WORD_3, 64'h8000_0000_0000_0001));
    // Writes past the register list must leave the key alone.
    add_row(reg_row(CFG_PAST_END, ALL_ONES));
    add_row(reg_row(CFG_IDX_LAST, 64'h0F0F_0F0F_0F0F_0F0F));
    add_row(req_row(ACT_RESTART, 8'h00, 1'b0));
    add_row(req_row(ACT_RESTART, 8'h00, 1'b0));
    add_row(req_row(ACT_DATA, 8'h3C, 1'b0));
    add_row(reg_row(CFG_KEY_LENGTH, 64'd1));
    add_row(req_row(ACT_RESTART, 8'h00, 1'b0));
    add_row(req_row(ACT_DATA, 8'hC3, 1'b1));
    add_row(reg_row(CFG_KEY_LENGTH, {{(CFG_DATA_W-KEY_LEN_W){1'b0}}, KEY_LEN_MAX}));
    add_row(req_row(ACT_RESTART, 8'h00, 1'b0));
    add_row(req_row(ACT_DATA, 8'h00, 1'b1));

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    throttle_in  = 1'b1;
    throttle_out = 1'b1;
    foreach (script[r]) begin
      if (script[r].kind == ROW_REG_WRITE) begin
        write_reg(script[r].reg_idx, script[r].reg_val);
      end else begin
        send_request(script[r].act, script[r].data, script[r].eom, script[r].known,
                     script[r].known_ks);
      end
    end

    // Random phases: mostly a fresh key, a restart and a few messages, with
    // stray restarts and odd message-end flags mixed in.
    while (requests_sent < TARGET_REQUESTS) begin
      if (requests_sent < CALM_FROM) begin
        throttle_in  = $urandom_range(0, 3) != 0;
        throttle_out = $urandom_range(0, 3) != 0;
      end
      if ($urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 5))
          0:       len = '0;
          1:       len = 6'd1;
          2:       len = KEY_LEN_MAX;
          3:       len = '1;
          default: len = KEY_LEN_W'($urandom_range(1, 63));
        endcase
        val = {$urandom, $urandom};
        val[KEY_LEN_W-1:0] = len;
        write_reg(CFG_KEY_LENGTH, val);
        for (k = 0; k < KEY_WORDS; k++) begin
          if ($urandom_range(0, 1) == 1) write_reg(CFG_KEY_WORD_0 + k[CFG_IDX_W-1:0],
                                                   random_word());
        end
        if ($urandom_range(0, 7) == 0) begin
          write_reg(CFG_IDX_W'($urandom_range(CFG_PAST_END, CFG_IDX_LAST)), random_word());
        end
      end
      if ($urandom_range(0, 7) != 0) send_request(ACT_RESTART, 8'($urandom), 1'($urandom),
                                                  1'b0, '0);
      msgs = $urandom_range(1, 3);
      for (m = 0; m < msgs; m++) begin
        msg_len = $urandom_range(1, 24);
        for (b = 0; b < msg_len; b++) begin
          if ($urandom_range(0, 39) == 0) begin
            send_request(ACT_RESTART, 8'($urandom), 1'($urandom), 1'b0, '0);
          end
          eom = (b == msg_len - 1);
          if ($urandom_range(0, 19) == 0) eom = ~eom;
          send_request(ACT_DATA, 8'($urandom), eom, 1'b0, '0);
        end
      end
    end

    in_release();
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (schedule_pending ? SCHEDULE_WAIT : TAIL_WAIT) @(posedge clk);

    $display("Sent %0d requests, %0d of them key restarts, with %0d register writes.",
             requests_sent, restarts_sent, reg_writes);
    $display("Checked %0d cipher bytes and found %0d mismatches.", bytes_checked, errors);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
